/* sv/ring_deque_with_high_water_core_assert.svh */
// Assertion macros shared by the queue core.
// Each macro samples on the rising edge of clk and is muted while rst_n is low.
`ifndef RING_DEQUE_WITH_HIGH_WATER_CORE_ASSERT_SVH
`define RING_DEQUE_WITH_HIGH_WATER_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define RDQ_ASSERT_SAME(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define RDQ_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rdq_pkg.sv */
package rdq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int WORD_W      = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request codes
  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_PUSH_TAIL = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_HEAD = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DROP      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_POP       = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ_MARK = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd6;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Stream packing
  localparam int IN_BITS  = ACT_W + WORD_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = WORD_W + 2 + 2 * CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = 1;
  localparam int CQ_CNT_W = 2;

  // Classified request
  typedef struct packed {
    logic              push;
    logic              at_head;
    logic              take;
    logic              read;
    logic              advance;
    logic              read_mark;
    logic              clear;
    logic [WORD_W-1:0] word;
  } cmd_t;

  // Result fields
  typedef struct packed {
    logic [WORD_W-1:0] message;
    status_t           status;
    logic [CNT_W-1:0]  pending;
    logic [CNT_W-1:0]  mark;
  } res_t;

endpackage

/* sv/rdq_front.sv */
module rdq_front (
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [rdq_pkg::IN_W-1:0]  in_tdata,
  output logic                      cmd_valid,
  input  logic                      cmd_ready,
  output rdq_pkg::cmd_t             cmd
);

  logic [rdq_pkg::ACT_W-1:0] action;

  assign action    = in_tdata[rdq_pkg::ACT_W-1:0];
  assign cmd_valid = in_tvalid;
  assign in_tready = cmd_ready;

  // Classify the request into control flags
  always_comb begin
    cmd           = '0;
    cmd.word      = in_tdata[rdq_pkg::ACT_W +: rdq_pkg::WORD_W];
    case (action)
      rdq_pkg::ACT_PUSH_TAIL: begin
        cmd.push = 1'b1;
      end
      rdq_pkg::ACT_PUSH_HEAD: begin
        cmd.push    = 1'b1;
        cmd.at_head = 1'b1;
      end
      rdq_pkg::ACT_PEEK: begin
        cmd.take = 1'b1;
        cmd.read = 1'b1;
      end
      rdq_pkg::ACT_DROP: begin
        cmd.take    = 1'b1;
        cmd.advance = 1'b1;
      end
      rdq_pkg::ACT_POP: begin
        cmd.take    = 1'b1;
        cmd.read    = 1'b1;
        cmd.advance = 1'b1;
      end
      rdq_pkg::ACT_READ_MARK: begin
        cmd.read_mark = 1'b1;
      end
      rdq_pkg::ACT_CLEAR: begin
        cmd.clear = 1'b1;
      end
      default: begin
        cmd.push = 1'b0;
      end
    endcase
  end

endmodule

/* sv/rdq_cmd_queue.sv */
module rdq_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  rdq_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output rdq_pkg::cmd_t rd_cmd
);

  rdq_pkg::cmd_t                  slot_r [rdq_pkg::CQ_DEPTH];
  logic [rdq_pkg::CQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rdq_pkg::CQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rdq_pkg::CQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                           do_wr, do_rd;

  assign wr_ready = (cnt_r != rdq_pkg::CQ_CNT_W'(rdq_pkg::CQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

/* sv/rdq_back.sv */
module rdq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  rdq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output rdq_pkg::res_t res
);

  logic [rdq_pkg::WORD_W-1:0] mem [rdq_pkg::QUEUE_DEPTH];

  logic [rdq_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [rdq_pkg::PTR_W-1:0]  tail_r, tail_nxt;
  logic [rdq_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [rdq_pkg::CNT_W-1:0]  peak_r, peak_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [rdq_pkg::WORD_W-1:0] rd_data_r;
  logic                       msg_en_r;
  rdq_pkg::status_t           status_r, status_nxt;
  logic [rdq_pkg::CNT_W-1:0]  pend_r;
  logic [rdq_pkg::CNT_W-1:0]  mark_r, mark_nxt;

  logic                       go;
  logic                       full, empty;
  logic                       push_ok, take_ok;
  logic [rdq_pkg::PTR_W-1:0]  head_dec, head_inc, tail_inc;
  logic [rdq_pkg::PTR_W-1:0]  wr_addr;

  localparam logic [rdq_pkg::PTR_W-1:0] LastIdx = rdq_pkg::PTR_W'(rdq_pkg::QUEUE_DEPTH - 1);

  // Execute when the result slot is free or drains this cycle
  assign go        = cmd_valid && (!out_valid_r || res_ready);
  assign cmd_ready = go;

  assign full     = (cnt_r == rdq_pkg::CNT_W'(rdq_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign push_ok  = cmd.push && !full;
  assign take_ok  = cmd.take && !empty;
  assign head_dec = (head_r == '0) ? LastIdx : head_r - 1'b1;
  assign head_inc = (head_r == LastIdx) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LastIdx) ? '0 : tail_r + 1'b1;
  assign wr_addr  = cmd.at_head ? head_dec : tail_r;

  // Next pointers, count, mark and status
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    peak_nxt   = peak_r;
    status_nxt = rdq_pkg::ST_OK;
    if (cmd.push && full) begin
      status_nxt = rdq_pkg::ST_OVERFLOW;
    end
    if (cmd.take && empty) begin
      status_nxt = rdq_pkg::ST_EMPTY;
    end
    if (push_ok) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cmd.at_head) begin
        head_nxt = head_dec;
      end else begin
        tail_nxt = tail_inc;
      end
      if (cnt_nxt > peak_r) begin
        peak_nxt = cnt_nxt;
      end
    end
    if (take_ok && cmd.advance) begin
      head_nxt = head_inc;
      cnt_nxt  = cnt_r - 1'b1;
    end
    if (cmd.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
      peak_nxt = '0;
    end
    mark_nxt = peak_nxt;
    if (cmd.read_mark) begin
      peak_nxt = '0;
    end
  end

  // Hold result slot valid until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (go) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
        peak_r <= peak_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (go) begin
      msg_en_r <= cmd.read && !empty;
      status_r <= status_nxt;
      pend_r   <= cnt_nxt;
      mark_r   <= mark_nxt;
    end
  end

  // Entry store: at most one write and one registered read per beat
  always_ff @(posedge clk) begin
    if (go && push_ok) begin
      mem[wr_addr] <= cmd.word;
    end
    if (go) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign res_valid   = out_valid_r;
  assign res.message = msg_en_r ? rd_data_r : '0;
  assign res.status  = status_r;
  assign res.pending = pend_r;
  assign res.mark    = mark_r;

endmodule

/* sv/ring_deque_with_high_water_core.sv */
// Channel | Direction | Handshake           | Payload
// in_     | slave     | in_tvalid/in_tready | in_tdata: action, message_in
// out_    | master    | out_tvalid/out_tready | out_tdata: message_out, status,
//         |           |                     |   pending_count, high_mark
//
// One request per cycle sustained unless the output stalls; each accepted beat
// is registered first in the command queue, then in the back unit.
// The back unit sets the rate: at most one store write and one read per beat.
// Reset is synchronous on rst_n: pointers, counts and queue state clear;
// the entry store is not cleared.
// A stalled output holds one result while two more requests wait in the queue.
module ring_deque_with_high_water_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [2:0] action, [34:3] message_in, rest zero
  input  logic [rdq_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [31:0] message_out, [33:32] status, [38:34] pending_count,
  // [43:39] high_mark, rest zero
  output logic [rdq_pkg::OUT_W-1:0] out_tdata
);

`include "ring_deque_with_high_water_core_assert.svh"

  rdq_pkg::cmd_t front_cmd, back_cmd;
  logic          front_valid, front_ready;
  logic          back_valid, back_ready;
  rdq_pkg::res_t res;

  rdq_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  rdq_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_cmd   (back_cmd)
  );

  rdq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack result fields from the low bit up
  assign out_tdata = rdq_pkg::OUT_W'({res.mark, res.pending, res.status, res.message});

  // Result checks
  `RDQ_ASSERT_SAME(a_overflow_full, out_tvalid && res.status == rdq_pkg::ST_OVERFLOW,
                   res.pending == rdq_pkg::CNT_W'(rdq_pkg::QUEUE_DEPTH),
                   "overflow reported on a queue that is not full")
  `RDQ_ASSERT_SAME(a_empty_result, out_tvalid && res.status == rdq_pkg::ST_EMPTY,
                   res.pending == '0 && res.message == '0,
                   "empty status with nonzero count or message")
  `RDQ_ASSERT_NEXT(a_result_follows, back_valid && back_ready, out_tvalid,
                   "executed command left no result")

endmodule

/* dv/ring_deque_with_high_water_core_tb.sv */
`timescale 1ns / 100ps

module ring_deque_with_high_water_core_tb;
  import rdq_pkg::*;

  // Code the block leaves unused: no state change, plain ok reply
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int RESET_CYCLES = 9;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 12;
  localparam int RANDOM_PER_PHASE = 320;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] word;
  } request_t;

  typedef struct {
    logic [WORD_W-1:0] message;
    status_t           status;
    logic [CNT_W-1:0]  pending;
    logic [CNT_W-1:0]  mark;
  } reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  request_t request_backlog[$];
  reply_t   expected_replies[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Shadow copy of the queue
  logic [WORD_W-1:0] shadow_store[QUEUE_DEPTH];
  logic [PTR_W-1:0]  shadow_head = '0;
  logic [PTR_W-1:0]  shadow_tail = '0;
  logic [CNT_W-1:0]  shadow_held = '0;
  logic [CNT_W-1:0]  shadow_peak = '0;

  ring_deque_with_high_water_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the shadow queue and queue up its reply
  function automatic void predict_queue_reply(logic [ACT_W-1:0] action,
                                              logic [WORD_W-1:0] word);
    reply_t r;
    r.message = '0;
    r.status  = ST_OK;
    case (action)
      ACT_PUSH_TAIL, ACT_PUSH_HEAD: begin
        if (shadow_held < QUEUE_DEPTH) begin
          if (action == ACT_PUSH_TAIL) begin
            shadow_store[shadow_tail] = word;
            shadow_tail = shadow_tail + 1'b1;
          end else begin
            // head pointer wraps below zero at the pointer width
            shadow_head = shadow_head - 1'b1;
            shadow_store[shadow_head] = word;
          end
          shadow_held = shadow_held + 1'b1;
          if (shadow_held > shadow_peak) shadow_peak = shadow_held;
        end else begin
          r.status = ST_OVERFLOW;
        end
      end
      ACT_PEEK, ACT_DROP, ACT_POP: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (action != ACT_DROP) r.message = shadow_store[shadow_head];
          if (action != ACT_PEEK) begin
            shadow_head = shadow_head + 1'b1;
            shadow_held = shadow_held - 1'b1;
          end
        end
      end
      ACT_CLEAR: begin
        shadow_head = '0;
        shadow_tail = '0;
        shadow_held = '0;
        shadow_peak = '0;
      end
      default: ;
    endcase
    r.pending = shadow_held;
    r.mark    = shadow_peak;
    // read-clear reports the mark before dropping it
    if (action == ACT_READ_MARK) shadow_peak = '0;
    expected_replies.push_back(r);
  endfunction

  // Driver: hold a beat until taken, then maybe idle before the next one
  always @(posedge clk) begin
    logic            next_valid;
    logic [IN_W-1:0] next_data;
    request_t        req;
    next_valid = in_tvalid;
    next_data  = in_tdata;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_queue_reply(in_tdata[ACT_W-1:0], in_tdata[ACT_W +: WORD_W]);
        next_valid = 1'b0;
      end
      if (!next_valid && request_backlog.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        req = request_backlog.pop_front();
        next_valid = 1'b1;
        next_data = '0;
        next_data[ACT_W-1:0] = req.action;
        next_data[ACT_W +: WORD_W] = req.word;
      end
    end
    in_tvalid <= next_valid;
    in_tdata  <= next_data;
  end

  // Monitor: check each reply beat against the oldest prediction
  always @(posedge clk) begin
    reply_t exp_r;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected reply beat: %h", out_tdata);
        mismatches++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (out_tdata[31:0] !== exp_r.message) begin
          $error("message_out: expected %h, got %h", exp_r.message, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[33:32] !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_tdata[33:32]);
          mismatches++;
        end
        if (out_tdata[38:34] !== exp_r.pending) begin
          $error("pending_count: expected %0d, got %0d", exp_r.pending, out_tdata[38:34]);
          mismatches++;
        end
        if (out_tdata[43:39] !== exp_r.mark) begin
          $error("high_mark: expected %0d, got %0d", exp_r.mark, out_tdata[43:39]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with work outstanding but no beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (request_backlog.size() == 0 && !in_tvalid && expected_replies.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("** ring_deque_with_high_water_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_request(logic [ACT_W-1:0] action, logic [WORD_W-1:0] word);
    request_t req;
    req.action = action;
    req.word   = word;
    request_backlog.push_back(req);
  endtask

  // Hold off new traffic until every reply is back
  task automatic wait_drained();
    do @(negedge clk);
    while (request_backlog.size() > 0 || in_tvalid || expected_replies.size() > 0);
  endtask

  // Bursts that lean toward filling or draining so full and empty both get hit
  task automatic queue_random_traffic(int unsigned count);
    int unsigned left;
    int unsigned burst;
    int unsigned style;
    int unsigned push_pct;
    int unsigned roll;
    logic [WORD_W-1:0] word;
    logic [ACT_W-1:0]  action;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(40, 8);
      if (burst > left) burst = left;
      style = $urandom_range(2);
      push_pct = (style == 0) ? 85 : (style == 1) ? 15 : 50;
      repeat (burst) begin
        roll = $urandom_range(99);
        case ($urandom_range(7))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom;
        endcase
        if (roll < 2) begin
          action = ACT_READ_MARK;
        end else if (roll < 4) begin
          action = ACT_CLEAR;
        end else if (roll < 5) begin
          action = ACT_UNUSED;
        end else if ($urandom_range(99) < push_pct) begin
          action = $urandom_range(1) ? ACT_PUSH_HEAD : ACT_PUSH_TAIL;
        end else begin
          case ($urandom_range(2))
            0:       action = ACT_PEEK;
            1:       action = ACT_DROP;
            default: action = ACT_POP;
          endcase
        end
        queue_request(action, word);
      end
      left -= burst;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty takes, both push ends with edge words, head wrap,
    // mark read-clear, clear, and the unused code
    queue_request(ACT_PEEK, $urandom);
    queue_request(ACT_DROP, $urandom);
    queue_request(ACT_POP, $urandom);
    queue_request(ACT_READ_MARK, $urandom);
    queue_request(ACT_UNUSED, $urandom);
    queue_request(ACT_PUSH_TAIL, 32'h0000_0000);
    queue_request(ACT_PUSH_TAIL, 32'hFFFF_FFFF);
    queue_request(ACT_PUSH_HEAD, 32'h8000_0001);
    queue_request(ACT_PEEK, $urandom);
    queue_request(ACT_UNUSED, $urandom);
    queue_request(ACT_POP, $urandom);
    queue_request(ACT_DROP, $urandom);
    queue_request(ACT_POP, $urandom);
    queue_request(ACT_POP, $urandom);
    queue_request(ACT_READ_MARK, $urandom);
    queue_request(ACT_READ_MARK, $urandom);
    queue_request(ACT_PUSH_HEAD, 32'h7FFF_FFFF);
    queue_request(ACT_PUSH_TAIL, 32'h5A5A_A5A5);
    queue_request(ACT_CLEAR, $urandom);
    queue_request(ACT_PEEK, $urandom);
    queue_request(ACT_PUSH_TAIL, 32'hFFFF_FFFF);
    queue_request(ACT_POP, $urandom);
    wait_drained();

    // Random phases: free running, idle sender, stalled receiver, both
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 77 : (phase == 3) ? 29 : 0;
      recv_stall_pct = (phase == 2) ? 77 : (phase == 3) ? 29 : 0;
      queue_random_traffic(RANDOM_PER_PHASE);
      wait_drained();
    end

    // Let any stray reply show up before the verdict
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_replies.size() > 0) begin
      $error("%0d replies never arrived", expected_replies.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("** ring_deque_with_high_water_core: PASSED **");
    end else begin
      $display("** ring_deque_with_high_water_core: FAILED **");
    end
    $finish;
  end

endmodule
